// ----- rtl/assert_macros.svh -----
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every sampled edge
`define TSQ_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define TSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tsq_pkg.sv -----
package tsq_pkg;

	// channel count and tick counter width
	localparam int NUM_CHANNELS = 3;
	localparam int COUNT_BITS   = 8;

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int LIM_W    = 8;
	localparam int CMP_W    = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;
	localparam int OUT_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CH_IDX_W-1:0]   LAST_CH   = CH_IDX_W'(NUM_CHANNELS - 1);
	localparam logic [CH_IDX_W-1:0]   SECOND_CH = CH_IDX_W'(1);
	localparam logic [1:0]            CH_MAX    = 2'(NUM_CHANNELS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// request kinds
	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_TRIGGER = 3'd1;
	localparam logic [2:0] KIND_PRESS   = 3'd2;
	localparam logic [2:0] KIND_RELEASE = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	// channel two drive modes
	localparam logic [1:0] CH2_TRIAC_ONLY = 2'd1;
	localparam logic [1:0] CH2_RELAY_ONLY = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ON_RELAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_TRIAC  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_RELAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TRIAC = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLOAD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CH2_MODE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SW_MODE   = 3'd6;

	// register reset values
	localparam logic [LIM_W-1:0] ON_RELAY_RST  = 8'd10;
	localparam logic [LIM_W-1:0] ON_TRIAC_RST  = 8'd14;
	localparam logic [LIM_W-1:0] OFF_RELAY_RST = 8'd4;
	localparam logic [LIM_W-1:0] OFF_TRIAC_RST = 8'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_CHAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [LIM_W-1:0] on_relay;
		logic [LIM_W-1:0] on_triac;
		logic [LIM_W-1:0] off_relay;
		logic [LIM_W-1:0] off_triac;
		logic             overload;
		logic [1:0]       ch2_mode;
		logic             sw_mode;
	} cfg_t;

	typedef struct packed {
		logic load_ok;
		logic error_any;
		logic any_light_on;
	} tick_in_t;

	typedef struct packed {
		logic                  status;
		logic                  pend_trig;
		logic                  pend_cmd;
		logic                  seq;
		logic                  rdone;
		logic                  relay;
		logic                  triac;
		logic [COUNT_BITS-1:0] count;
	} chan_t;

	typedef struct packed {
		logic busy;
		logic load_on;
	} gate_t;

	typedef struct packed {
		logic                in_ready;
		logic                do_cmd;
		logic                do_chan;
		logic                first;
		logic                load_out;
		logic [CH_IDX_W-1:0] ch_idx;
	} ctrl_t;

endpackage

// ----- rtl/tsq_chan_unit.sv -----
module tsq_chan_unit (
	input  logic             first,
	input  logic             is_ch2,
	input  tsq_pkg::cfg_t     cfg,
	input  tsq_pkg::tick_in_t tick,
	input  tsq_pkg::chan_t    chan_in,
	input  tsq_pkg::gate_t    gate_in,
	output tsq_pkg::chan_t    chan_out,
	output tsq_pkg::gate_t    gate_out,
	output logic             take
);

	logic                        blocked;
	logic [tsq_pkg::LIM_W-1:0]   lim;
	logic [tsq_pkg::COUNT_BITS-1:0] cnt_inc;

	always_comb begin
		chan_out = chan_in;
		gate_out = gate_in;
		take     = 1'b0;
		blocked  = 1'b0;
		lim      = '0;
		cnt_inc  = '0;

		// gate release at the start of the tick
		if (first && cfg.overload && gate_in.busy &&
			(tick.load_ok || tick.error_any || !tick.any_light_on)) begin
			gate_out.busy = 1'b0;
		end

		// take a pending request when idle and the gate allows
		if (!chan_out.seq && chan_out.pend_trig) begin
			blocked = cfg.overload && (tick.load_ok || gate_out.busy);
			if (!blocked) begin
				take = 1'b1;
				chan_out.pend_trig = 1'b0;
				if (chan_out.status != chan_out.pend_cmd) begin
					chan_out.status = chan_out.pend_cmd;
					if (is_ch2 && cfg.ch2_mode == tsq_pkg::CH2_TRIAC_ONLY) begin
						chan_out.triac = chan_out.pend_cmd;
					end else if (is_ch2 && cfg.ch2_mode == tsq_pkg::CH2_RELAY_ONLY) begin
						chan_out.relay = chan_out.pend_cmd;
					end else begin
						chan_out.triac = 1'b1;
						chan_out.count = '0;
						chan_out.seq   = 1'b1;
					end
				end
				if (cfg.overload) begin
					gate_out.load_on = chan_out.pend_cmd;
					gate_out.busy    = 1'b1;
				end
			end
		end

		// one step of the relay/triac timing, single shared compare
		if (chan_out.seq) begin
			if (chan_out.rdone) begin
				lim = chan_out.status ? cfg.on_triac : cfg.off_triac;
			end else begin
				lim = chan_out.status ? cfg.on_relay : cfg.off_relay;
			end
			cnt_inc = (chan_out.count != tsq_pkg::COUNT_MAX) ?
				chan_out.count + 1'b1 : chan_out.count;
			chan_out.count = cnt_inc;
			if (tsq_pkg::CMP_W'(cnt_inc) >= tsq_pkg::CMP_W'(lim)) begin
				if (!chan_out.rdone) begin
					chan_out.rdone = 1'b1;
					chan_out.relay = chan_out.status;
				end else begin
					chan_out.count = '0;
					chan_out.seq   = 1'b0;
					chan_out.rdone = 1'b0;
					chan_out.triac = 1'b0;
				end
			end
		end
	end

endmodule

// ----- rtl/tsq_fsm.sv -----
module tsq_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           is_tick,
	input  logic           out_free,
	output tsq_pkg::ctrl_t ctrl
);

	tsq_pkg::state_t                 state_q, state_nxt;
	logic [tsq_pkg::CH_IDX_W-1:0]    idx_q;

	// state and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsq_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == tsq_pkg::ST_CHAN && idx_q != tsq_pkg::LAST_CH) begin
				idx_q <= idx_q + 1'b1;
			end else if (state_q != tsq_pkg::ST_CHAN) begin
				idx_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tsq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = is_tick ? tsq_pkg::ST_CHAN : tsq_pkg::ST_CMD;
				end
			end
			tsq_pkg::ST_CMD: state_nxt = tsq_pkg::ST_DONE;
			tsq_pkg::ST_CHAN: begin
				if (idx_q == tsq_pkg::LAST_CH) begin
					state_nxt = tsq_pkg::ST_DONE;
				end
			end
			tsq_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = tsq_pkg::ST_IDLE;
				end
			end
			default: state_nxt = tsq_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		ctrl.ch_idx = idx_q;
		case (state_q)
			tsq_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
			tsq_pkg::ST_CMD:  ctrl.do_cmd   = 1'b1;
			tsq_pkg::ST_CHAN: begin
				ctrl.do_chan = 1'b1;
				ctrl.first   = (idx_q == '0);
			end
			tsq_pkg::ST_DONE: ctrl.load_out = out_free;
			default: ctrl = '0;
		endcase
	end

endmodule

// ----- rtl/triac_relay_switch_sequencer_top.sv -----
// Hybrid triac-relay switch sequencer for up to three lighting channels.
// Input channel: in_valid/in_ready with kind, channel, command_on and the
// load_ok/error_any/any_light_on status read on ticks. Each request yields
// exactly one result on out_valid/out_ready: relay, triac and light status
// per channel plus the overload gate status, all showing the state after
// that request.
// Timing: a tick walks the channels through one shared timing unit, one
// channel per cycle, in the steps accept, one step per channel and result
// load, and in_ready returns after the load. Trigger, press, release and
// error close go through accept, update and result load.
// The result appears on the output register in the cycle after the load.
// The input is taken while an older result still waits in the output
// register; if the receiver stalls, the next result holds in the sequencer
// until the output register frees, and no further request is taken.
// Registers are written through cfg_we/cfg_index/cfg_wdata with no wait.
// Reset (arst_n low) clears all channel state and the gate and loads the
// default timing registers; the output register comes up empty.
`include "assert_macros.svh"

module triac_relay_switch_sequencer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     kind,
	input  logic [1:0]                     channel,
	input  logic                           command_on,
	input  logic                           load_ok,
	input  logic                           error_any,
	input  logic                           any_light_on,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tsq_pkg::OUT_W-1:0]      relay_drive,
	output logic [tsq_pkg::OUT_W-1:0]      triac_drive,
	output logic [tsq_pkg::OUT_W-1:0]      light_status,
	output logic                           load_busy,
	output logic                           load_on,
	output logic [1:0]                     active_line
);

	localparam int N = tsq_pkg::NUM_CHANNELS;

	tsq_pkg::cfg_t     cfg_q;
	tsq_pkg::ctrl_t    ctrl;
	tsq_pkg::tick_in_t tick_q;
	tsq_pkg::chan_t    unit_in, unit_out;
	tsq_pkg::gate_t    gate_q, gate_nxt, unit_gate;
	logic              take;
	logic              is_ch2;
	logic              out_free;
	logic              out_valid_q;

	logic [2:0] kind_q;
	logic [1:0] channel_q;
	logic       command_on_q;

	// per-channel state
	logic [N-1:0] status_q, ptrig_q, pcmd_q, seq_q, rdone_q, relay_q, triac_q;
	logic [N-1:0] pseen_q, pton_q, line_q;
	logic [tsq_pkg::COUNT_BITS-1:0] cnt_q [N];

	logic [N-1:0] status_nxt, ptrig_nxt, pcmd_nxt, seq_nxt, rdone_nxt, relay_nxt;
	logic [N-1:0] triac_nxt, pseen_nxt, pton_nxt, line_nxt;
	logic [tsq_pkg::COUNT_BITS-1:0] cnt_nxt [N];

	logic                         ch_ok;
	logic                         momentary;
	logic [tsq_pkg::CH_IDX_W-1:0] ci;

	logic [tsq_pkg::OUT_W-1:0] relay_v, triac_v, status_v;
	logic [1:0]                line_v;

	logic [tsq_pkg::OUT_W-1:0] relay_res_q, triac_res_q, status_res_q;
	logic                      busy_res_q, load_on_res_q;
	logic [1:0]                line_res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_relay  <= tsq_pkg::ON_RELAY_RST;
			cfg_q.on_triac  <= tsq_pkg::ON_TRIAC_RST;
			cfg_q.off_relay <= tsq_pkg::OFF_RELAY_RST;
			cfg_q.off_triac <= tsq_pkg::OFF_TRIAC_RST;
			cfg_q.overload  <= 1'b0;
			cfg_q.ch2_mode  <= '0;
			cfg_q.sw_mode   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tsq_pkg::REG_ON_RELAY:  cfg_q.on_relay  <= cfg_wdata;
				tsq_pkg::REG_ON_TRIAC:  cfg_q.on_triac  <= cfg_wdata;
				tsq_pkg::REG_OFF_RELAY: cfg_q.off_relay <= cfg_wdata;
				tsq_pkg::REG_OFF_TRIAC: cfg_q.off_triac <= cfg_wdata;
				tsq_pkg::REG_OVERLOAD:  cfg_q.overload  <= cfg_wdata[0];
				tsq_pkg::REG_CH2_MODE:  cfg_q.ch2_mode  <= cfg_wdata[1:0];
				tsq_pkg::REG_SW_MODE:   cfg_q.sw_mode   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer
	assign out_free = !out_valid_q || out_ready;

	tsq_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_tick  (kind == tsq_pkg::KIND_TICK),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	assign in_ready = ctrl.in_ready;

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && ctrl.in_ready) begin
			kind_q         <= kind;
			channel_q      <= channel;
			command_on_q   <= command_on;
			tick_q.load_ok      <= load_ok;
			tick_q.error_any    <= error_any;
			tick_q.any_light_on <= any_light_on;
		end
	end

	// shared channel timing unit, fed from the selected channel
	always_comb begin
		unit_in.status    = status_q[ctrl.ch_idx];
		unit_in.pend_trig = ptrig_q[ctrl.ch_idx];
		unit_in.pend_cmd  = pcmd_q[ctrl.ch_idx];
		unit_in.seq       = seq_q[ctrl.ch_idx];
		unit_in.rdone     = rdone_q[ctrl.ch_idx];
		unit_in.relay     = relay_q[ctrl.ch_idx];
		unit_in.triac     = triac_q[ctrl.ch_idx];
		unit_in.count     = cnt_q[ctrl.ch_idx];
	end

	assign is_ch2 = (ctrl.ch_idx == tsq_pkg::SECOND_CH);

	tsq_chan_unit u_unit (
		.first    (ctrl.first),
		.is_ch2   (is_ch2),
		.cfg      (cfg_q),
		.tick     (tick_q),
		.chan_in  (unit_in),
		.gate_in  (gate_q),
		.chan_out (unit_out),
		.gate_out (unit_gate),
		.take     (take)
	);

	// decoded request channel
	always_comb begin
		ch_ok     = (channel_q inside {[2'd1 : tsq_pkg::CH_MAX]});
		ci        = tsq_pkg::CH_IDX_W'(channel_q - 2'd1);
		momentary = cfg_q.sw_mode && (ci == tsq_pkg::SECOND_CH);
	end

	// next channel state: timing step or command update
	always_comb begin
		status_nxt = status_q;
		ptrig_nxt  = ptrig_q;
		pcmd_nxt   = pcmd_q;
		seq_nxt    = seq_q;
		rdone_nxt  = rdone_q;
		relay_nxt  = relay_q;
		triac_nxt  = triac_q;
		pseen_nxt  = pseen_q;
		pton_nxt   = pton_q;
		line_nxt   = line_q;
		cnt_nxt    = cnt_q;
		gate_nxt   = gate_q;

		if (ctrl.do_chan) begin
			status_nxt[ctrl.ch_idx] = unit_out.status;
			ptrig_nxt[ctrl.ch_idx]  = unit_out.pend_trig;
			pcmd_nxt[ctrl.ch_idx]   = unit_out.pend_cmd;
			seq_nxt[ctrl.ch_idx]    = unit_out.seq;
			rdone_nxt[ctrl.ch_idx]  = unit_out.rdone;
			relay_nxt[ctrl.ch_idx]  = unit_out.relay;
			triac_nxt[ctrl.ch_idx]  = unit_out.triac;
			cnt_nxt[ctrl.ch_idx]    = unit_out.count;
			gate_nxt                = unit_gate;
			if (take && cfg_q.overload) begin
				for (int k = 0; k < N; k++) begin
					line_nxt[k] = unit_in.pend_cmd &&
						(ctrl.ch_idx == tsq_pkg::CH_IDX_W'(k));
				end
			end
		end

		if (ctrl.do_cmd) begin
			case (kind_q)
				tsq_pkg::KIND_TRIGGER: begin
					if (ch_ok) begin
						ptrig_nxt[ci] = 1'b1;
						pcmd_nxt[ci]  = command_on_q;
					end
				end
				tsq_pkg::KIND_PRESS: begin
					if (ch_ok) begin
						if (!momentary) begin
							pseen_nxt[ci] = 1'b1;
							pton_nxt[ci]  = !status_q[ci];
						end
						if (!status_q[ci]) begin
							ptrig_nxt[ci] = 1'b1;
							pcmd_nxt[ci]  = 1'b1;
						end
					end
				end
				tsq_pkg::KIND_RELEASE: begin
					if (ch_ok) begin
						if (momentary) begin
							if (status_q[ci]) begin
								ptrig_nxt[ci] = 1'b1;
								pcmd_nxt[ci]  = 1'b0;
							end
						end else if (pseen_q[ci]) begin
							pseen_nxt[ci] = 1'b0;
							if (!pton_q[ci]) begin
								ptrig_nxt[ci] = 1'b1;
								pcmd_nxt[ci]  = 1'b0;
							end
						end
					end
				end
				tsq_pkg::KIND_ERROR: begin
					if (channel_q == 2'd0) begin
						for (int k = 0; k < N; k++) begin
							if (status_q[k]) begin
								ptrig_nxt[k] = 1'b1;
								pcmd_nxt[k]  = 1'b0;
							end
						end
					end else if (ch_ok && status_q[ci]) begin
						ptrig_nxt[ci] = 1'b1;
						pcmd_nxt[ci]  = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// channel and gate state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			ptrig_q  <= '0;
			pcmd_q   <= '0;
			seq_q    <= '0;
			rdone_q  <= '0;
			relay_q  <= '0;
			triac_q  <= '0;
			pseen_q  <= '0;
			pton_q   <= '0;
			line_q   <= '0;
			gate_q   <= '0;
			for (int k = 0; k < N; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			status_q <= status_nxt;
			ptrig_q  <= ptrig_nxt;
			pcmd_q   <= pcmd_nxt;
			seq_q    <= seq_nxt;
			rdone_q  <= rdone_nxt;
			relay_q  <= relay_nxt;
			triac_q  <= triac_nxt;
			pseen_q  <= pseen_nxt;
			pton_q   <= pton_nxt;
			line_q   <= line_nxt;
			gate_q   <= gate_nxt;
			cnt_q    <= cnt_nxt;
		end
	end

	// result vectors, active line is the lowest marked channel
	always_comb begin
		relay_v  = '0;
		triac_v  = '0;
		status_v = '0;
		line_v   = '0;
		for (int k = N - 1; k >= 0; k--) begin
			relay_v[k]  = relay_q[k];
			triac_v[k]  = triac_q[k];
			status_v[k] = status_q[k];
			if (line_q[k]) begin
				line_v = 2'(k + 1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			relay_res_q   <= relay_v;
			triac_res_q   <= triac_v;
			status_res_q  <= status_v;
			busy_res_q    <= gate_q.busy;
			load_on_res_q <= gate_q.load_on;
			line_res_q    <= line_v;
		end
	end

	assign out_valid    = out_valid_q;
	assign relay_drive  = relay_res_q;
	assign triac_drive  = triac_res_q;
	assign light_status = status_res_q;
	assign load_busy    = busy_res_q;
	assign load_on      = load_on_res_q;
	assign active_line  = line_res_q;

	// checks
	`TSQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"request taken while previous one in progress")
	`TSQ_ASSERT_ALWAYS(a_triac_during_seq, (seq_q & ~triac_q) == '0,
		"triac released while channel still sequencing")
	`TSQ_ASSERT_ALWAYS(a_rdone_needs_seq, (rdone_q & ~seq_q) == '0,
		"relay done flag set outside a sequence")
	`TSQ_ASSERT_ALWAYS(a_one_line_mark, $onehot0(line_q),
		"more than one channel carries the line mark")

endmodule

// ----- tb/triac_relay_switch_sequencer_top_tb.sv -----
module triac_relay_switch_sequencer_top_tb;

	// kinds that the block ignores, and the all-channels selector
	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
	localparam logic [1:0] CH_ALL         = 2'd0;
	localparam logic [1:0] CH2_SEQUENCED  = 2'd0;
	localparam logic [1:0] CH2_AS_SEQ     = 2'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] channel;
		logic       command_on;
		logic       load_ok;
		logic       error_any;
		logic       any_light_on;
		logic       drain_first;
	} sw_req_t;

	typedef struct packed {
		logic [tsq_pkg::OUT_W-1:0] relay;
		logic [tsq_pkg::OUT_W-1:0] triac;
		logic [tsq_pkg::OUT_W-1:0] light;
		logic                      busy;
		logic                      load_on;
		logic [1:0]                line;
	} drive_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tsq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [2:0]                     kind = '0;
	logic [1:0]                     channel = '0;
	logic                           command_on = 1'b0;
	logic                           load_ok = 1'b0;
	logic                           error_any = 1'b0;
	logic                           any_light_on = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [tsq_pkg::OUT_W-1:0]      relay_drive;
	logic [tsq_pkg::OUT_W-1:0]      triac_drive;
	logic [tsq_pkg::OUT_W-1:0]      light_status;
	logic                           load_busy;
	logic                           load_on;
	logic [1:0]                     active_line;

	triac_relay_switch_sequencer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.channel      (channel),
		.command_on   (command_on),
		.load_ok      (load_ok),
		.error_any    (error_any),
		.any_light_on (any_light_on),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.relay_drive  (relay_drive),
		.triac_drive  (triac_drive),
		.light_status (light_status),
		.load_busy    (load_busy),
		.load_on      (load_on),
		.active_line  (active_line)
	);

	// clock, period 10
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sw_req_t     requests_to_send[$];
	drive_t      expected_outputs[$];
	sw_req_t     drive_req;
	logic        req_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned queued_count = 0;
	int unsigned results_checked = 0;
	int unsigned requests_taken = 0;
	int unsigned ticks_taken = 0;
	int unsigned fail_count = 0;

	// shadow of the switch sequencer state
	tsq_pkg::cfg_t                     cfg_shadow;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_status = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_pend = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_pcmd = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_seq = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_rdone = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_press = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_press_on = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_mark = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_relay = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0] st_triac = '0;
	logic [tsq_pkg::NUM_CHANNELS-1:0][tsq_pkg::COUNT_BITS-1:0] st_count = '0;
	logic                              st_busy = 1'b0;
	logic                              st_load_on = 1'b0;

	// latch a switch request for a channel
	task automatic latch_switch(input int c, input logic on);
		st_pend[c] = 1'b1;
		st_pcmd[c] = on;
	endtask

	// take a latched request: new status, fire triac or drive directly
	task automatic take_switch(input int c, input logic on);
		int k;
		if (st_status[c] != on) begin
			st_status[c] = on;
			if (c == int'(tsq_pkg::SECOND_CH)
			    && cfg_shadow.ch2_mode == tsq_pkg::CH2_TRIAC_ONLY) begin
				st_triac[c] = on;
			end else if (c == int'(tsq_pkg::SECOND_CH)
			    && cfg_shadow.ch2_mode == tsq_pkg::CH2_RELAY_ONLY) begin
				st_relay[c] = on;
			end else begin
				st_triac[c] = 1'b1;
				st_count[c] = '0;
				st_seq[c] = 1'b1;
			end
		end
		if (cfg_shadow.overload) begin
			st_load_on = on;
			st_busy = 1'b1;
			for (k = 0; k < tsq_pkg::NUM_CHANNELS; k++)
				st_mark[k] = on && (k == c);
		end
	endtask

	// one tick of the relay/triac timing for a channel
	task automatic step_sequence(input int c);
		logic [tsq_pkg::LIM_W-1:0] relay_lim;
		logic [tsq_pkg::LIM_W-1:0] triac_lim;
		if (st_seq[c]) begin
			relay_lim = st_status[c] ? cfg_shadow.on_relay : cfg_shadow.off_relay;
			triac_lim = st_status[c] ? cfg_shadow.on_triac : cfg_shadow.off_triac;
			if (st_count[c] != tsq_pkg::COUNT_MAX)
				st_count[c] = st_count[c] + 1'b1;
			if (!st_rdone[c]) begin
				if (st_count[c] >= relay_lim) begin
					st_rdone[c] = 1'b1;
					st_relay[c] = st_status[c];
				end
			end else if (st_count[c] >= triac_lim) begin
				st_count[c] = '0;
				st_seq[c] = 1'b0;
				st_rdone[c] = 1'b0;
				st_triac[c] = 1'b0;
			end
		end
	endtask

	// apply one request to the shadow state and return the drive outputs
	task automatic predict_drive(input sw_req_t r, output drive_t res);
		logic chan_ok;
		logic momentary;
		int   c;
		int   k;
		chan_ok = r.channel inside {[2'd1 : tsq_pkg::CH_MAX]};
		c = chan_ok ? int'(r.channel) - 1 : 0;
		momentary = cfg_shadow.sw_mode && (c == int'(tsq_pkg::SECOND_CH));
		case (r.kind)
			tsq_pkg::KIND_TICK: begin
				if (cfg_shadow.overload && st_busy
				    && (r.load_ok || r.error_any || !r.any_light_on))
					st_busy = 1'b0;
				for (k = 0; k < tsq_pkg::NUM_CHANNELS; k++) begin
					if (!st_seq[k] && st_pend[k]
					    && !(cfg_shadow.overload && (r.load_ok || st_busy))) begin
						st_pend[k] = 1'b0;
						take_switch(k, st_pcmd[k]);
					end
					step_sequence(k);
				end
			end
			tsq_pkg::KIND_TRIGGER: begin
				if (chan_ok)
					latch_switch(c, r.command_on);
			end
			tsq_pkg::KIND_PRESS: begin
				if (chan_ok) begin
					if (!momentary) begin
						st_press[c] = 1'b1;
						st_press_on[c] = !st_status[c];
					end
					if (!st_status[c])
						latch_switch(c, 1'b1);
				end
			end
			tsq_pkg::KIND_RELEASE: begin
				if (chan_ok) begin
					if (momentary) begin
						if (st_status[c])
							latch_switch(c, 1'b0);
					end else if (st_press[c]) begin
						st_press[c] = 1'b0;
						if (!st_press_on[c])
							latch_switch(c, 1'b0);
					end
				end
			end
			tsq_pkg::KIND_ERROR: begin
				if (r.channel == CH_ALL) begin
					for (k = 0; k < tsq_pkg::NUM_CHANNELS; k++)
						if (st_status[k])
							latch_switch(k, 1'b0);
				end else if (chan_ok && st_status[c]) begin
					latch_switch(c, 1'b0);
				end
			end
			default: ;
		endcase
		res.relay = st_relay;
		res.triac = st_triac;
		res.light = st_status;
		res.busy = st_busy;
		res.load_on = st_load_on;
		res.line = '0;
		// lowest marked channel wins
		for (k = tsq_pkg::NUM_CHANNELS - 1; k >= 0; k--)
			if (st_mark[k])
				res.line = 2'(k + 1);
	endtask

	// request driver: payload changes on the falling edge
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct
			    && !(requests_to_send[0].drain_first && expected_outputs.size() != 0)) begin
				drive_req = requests_to_send.pop_front();
				in_valid <= 1'b1;
				kind <= drive_req.kind;
				channel <= drive_req.channel;
				command_on <= drive_req.command_on;
				load_ok <= drive_req.load_ok;
				error_any <= drive_req.error_any;
				any_light_on <= drive_req.any_light_on;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: check results, predict on each accepted request
	always @(posedge clk) begin
		drive_t  want;
		drive_t  got;
		sw_req_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.relay = relay_drive;
				got.triac = triac_drive;
				got.light = light_status;
				got.busy = load_busy;
				got.load_on = load_on;
				got.line = active_line;
				if (expected_outputs.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: relay %b triac %b light %b",
							got.relay, got.triac, got.light);
				end else begin
					want = expected_outputs.pop_front();
					results_checked++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch at result %0d", results_checked);
							$display("  expected relay %b triac %b light %b busy %b on %b line %0d",
								want.relay, want.triac, want.light, want.busy,
								want.load_on, want.line);
							$display("  got      relay %b triac %b light %b busy %b on %b line %0d",
								got.relay, got.triac, got.light, got.busy,
								got.load_on, got.line);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				req_taken = 1'b1;
				seen.kind = kind;
				seen.channel = channel;
				seen.command_on = command_on;
				seen.load_ok = load_ok;
				seen.error_any = error_any;
				seen.any_light_on = any_light_on;
				seen.drain_first = 1'b0;
				predict_drive(seen, want);
				expected_outputs.push_back(want);
				requests_taken++;
				if (kind == tsq_pkg::KIND_TICK)
					ticks_taken++;
			end
		end
	end

	task automatic push_req(input logic [2:0] k, input logic [1:0] ch, input logic cmd,
		input logic lok, input logic err, input logic anyon, input logic drain);
		sw_req_t r;
		r.kind = k;
		r.channel = ch;
		r.command_on = cmd;
		r.load_ok = lok;
		r.error_any = err;
		r.any_light_on = anyon;
		r.drain_first = drain;
		requests_to_send.push_back(r);
		if (k <= tsq_pkg::KIND_ERROR)
			queued_count++;
	endtask

	// random payload, status inputs biased toward a busy load
	task automatic push_random(input logic [2:0] k, input logic [1:0] ch);
		push_req(k, ch, 1'($urandom_range(1)), $urandom_range(99) < 25,
			$urandom_range(99) < 10, $urandom_range(99) < 85, $urandom_range(99) < 2);
	endtask

	task automatic push_ticks(input int unsigned max_ticks);
		int unsigned n;
		int unsigned j;
		n = $urandom_range(max_ticks);
		for (j = 0; j < n; j++)
			push_random(tsq_pkg::KIND_TICK, 2'($urandom_range(3)));
	endtask

	// one command followed by a run of ticks, presses often paired with a release
	task automatic add_burst(input int unsigned max_ticks);
		int unsigned pick;
		logic [2:0]  k;
		logic [1:0]  ch;
		logic        pair_release;
		pick = $urandom_range(99);
		ch = ($urandom_range(15) == 0) ? CH_ALL : 2'($urandom_range(3, 1));
		pair_release = 1'b0;
		if (pick < 35) begin
			k = tsq_pkg::KIND_TRIGGER;
		end else if (pick < 60) begin
			k = tsq_pkg::KIND_PRESS;
			pair_release = 1'($urandom_range(1));
		end else if (pick < 78) begin
			k = tsq_pkg::KIND_RELEASE;
		end else if (pick < 90) begin
			k = tsq_pkg::KIND_ERROR;
			if ($urandom_range(3) == 0)
				ch = CH_ALL;
		end else if (pick < 95) begin
			k = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
		end else begin
			k = tsq_pkg::KIND_TICK;
		end
		push_random(k, ch);
		push_ticks(max_ticks);
		if (pair_release) begin
			push_random(tsq_pkg::KIND_RELEASE, ch);
			push_ticks(max_ticks);
		end
	endtask

	task automatic queue_random_phase(input int unsigned n_items,
		input int unsigned max_ticks);
		int unsigned target;
		target = queued_count + n_items;
		while (queued_count < target)
			add_burst(max_ticks);
	endtask

	task automatic write_reg(input logic [tsq_pkg::CFG_IDX_W-1:0] idx,
		input logic [tsq_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			tsq_pkg::REG_ON_RELAY:  cfg_shadow.on_relay = val;
			tsq_pkg::REG_ON_TRIAC:  cfg_shadow.on_triac = val;
			tsq_pkg::REG_OFF_RELAY: cfg_shadow.off_relay = val;
			tsq_pkg::REG_OFF_TRIAC: cfg_shadow.off_triac = val;
			tsq_pkg::REG_OVERLOAD:  cfg_shadow.overload = val[0];
			tsq_pkg::REG_CH2_MODE:  cfg_shadow.ch2_mode = val[1:0];
			tsq_pkg::REG_SW_MODE:   cfg_shadow.sw_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [7:0] onr, input logic [7:0] ont,
		input logic [7:0] offr, input logic [7:0] offt, input logic ov,
		input logic [1:0] mode, input logic sw);
		write_reg(tsq_pkg::REG_ON_RELAY, onr);
		write_reg(tsq_pkg::REG_ON_TRIAC, ont);
		write_reg(tsq_pkg::REG_OFF_RELAY, offr);
		write_reg(tsq_pkg::REG_OFF_TRIAC, offt);
		write_reg(tsq_pkg::REG_OVERLOAD, tsq_pkg::CFG_DATA_W'(ov));
		write_reg(tsq_pkg::REG_CH2_MODE, tsq_pkg::CFG_DATA_W'(mode));
		write_reg(tsq_pkg::REG_SW_MODE, tsq_pkg::CFG_DATA_W'(sw));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every request is out and every result is back
	task automatic wait_until_quiet();
		while (requests_to_send.size() != 0 || in_valid || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		cfg_shadow.on_relay = tsq_pkg::ON_RELAY_RST;
		cfg_shadow.on_triac = tsq_pkg::ON_TRIAC_RST;
		cfg_shadow.off_relay = tsq_pkg::OFF_RELAY_RST;
		cfg_shadow.off_triac = tsq_pkg::OFF_TRIAC_RST;
		cfg_shadow.overload = 1'b0;
		cfg_shadow.ch2_mode = CH2_SEQUENCED;
		cfg_shadow.sw_mode = 1'b0;
		send_idle_pct = 27;
		recv_idle_pct = 52;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: toggle logic, bad channels, redundant requests, error close
		apply_config(8'd1, 8'd2, 8'd1, 8'd2, 1'b0, CH2_SEQUENCED, 1'b0);
		push_req(KIND_UNUSED_HI, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TRIGGER, CH_ALL, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TRIGGER, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TRIGGER, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_PRESS, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_RELEASE, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_PRESS, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_RELEASE, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_ERROR, CH_ALL, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
		wait_until_quiet();

		// directed: overload gate, momentary channel two, triac-only drive
		apply_config(8'd1, 8'd2, 8'd1, 8'd2, 1'b1, tsq_pkg::CH2_TRIAC_ONLY, 1'b1);
		push_req(tsq_pkg::KIND_PRESS, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TRIGGER, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_RELEASE, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
		push_req(tsq_pkg::KIND_TICK, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		wait_until_quiet();

		// random phases, sender idles less than receiver
		apply_config(tsq_pkg::ON_RELAY_RST, tsq_pkg::ON_TRIAC_RST, tsq_pkg::OFF_RELAY_RST,
			tsq_pkg::OFF_TRIAC_RST, 1'b0, CH2_SEQUENCED, 1'b0);
		queue_random_phase(250, 20);
		wait_until_quiet();
		apply_config(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, CH2_AS_SEQ, 1'b1);
		queue_random_phase(200, 4);
		wait_until_quiet();

		// receiver idles less than sender; longest delays saturate the counter
		send_idle_pct = 52;
		recv_idle_pct = 27;
		apply_config(8'd255, 8'd255, 8'd0, 8'd3, 1'b0, CH2_SEQUENCED, 1'b0);
		queue_random_phase(350, 60);
		wait_until_quiet();
		apply_config(8'd3, 8'd1, 8'd2, 8'd5, 1'b1, tsq_pkg::CH2_TRIAC_ONLY, 1'b1);
		queue_random_phase(250, 8);
		wait_until_quiet();

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_config(8'd5, 8'd9, 8'd1, 8'd255, 1'b1, tsq_pkg::CH2_RELAY_ONLY, 1'b0);
		queue_random_phase(200, 10);
		wait_until_quiet();
		apply_config(8'd2, 8'd4, 8'd3, 8'd6, 1'b1, CH2_SEQUENCED, 1'b1);
		queue_random_phase(200, 6);
		wait_until_quiet();
		repeat (10) @(posedge clk);

		$display("covered %0d requests (%0d ticks) over 8 register settings, %0d results checked",
			requests_taken, ticks_taken, results_checked);
		$display("failures: %0d", fail_count);
		if (fail_count == 0 && expected_outputs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run time limit
	initial begin
		#4000000;
		$display("timeout, %0d results still expected", expected_outputs.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
